[rtl/gha_pkg.sv]
// gha_pkg: shared types and constants for the generational handle allocator
// used by generational_handle_allocator, gha_bitpick and gha_checker
`default_nettype none
package gha_pkg;
    localparam int MAX_SLOTS     = 1024;
    localparam int WORD_BITS     = 64;
    localparam int NWORDS        = MAX_SLOTS / WORD_BITS;
    localparam int VERSION_LIMIT = 16383;
    localparam int POS_W         = $clog2(WORD_BITS);
    localparam int WORD_W        = $clog2(NWORDS);
    localparam int SLOT_W        = 10;
    localparam int VER_W         = 14;
    localparam int CNT_W         = 11;

    // request codes
    localparam logic [2:0] REQ_CREATE   = 3'd0;
    localparam logic [2:0] REQ_DESTROY  = 3'd1;
    localparam logic [2:0] REQ_EXISTS   = 3'd2;
    localparam logic [2:0] REQ_READ     = 3'd3;
    localparam logic [2:0] REQ_CLEAR    = 3'd4;
    localparam logic [2:0] REQ_SCAN_FWD = 3'd5;
    localparam logic [2:0] REQ_SCAN_REV = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_NO  = 2'd1;
    localparam logic [1:0] ST_IGN = 2'd2;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [SLOT_W-1:0] entity_index;
        logic [VER_W-1:0]  entity_version;
        logic [3:0]        word_index;
    } t_req_beat;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] out_index;
        logic [VER_W-1:0]  out_version;
        logic [CNT_W-1:0]  live_count;
        logic              last;
    } t_rsp_beat;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_USE,
        S_SCAN,
        S_SCAN_USE
    } t_state;
endpackage
`default_nettype wire

[rtl/generational_handle_allocator.sv]
// generational_handle_allocator: slot allocator with ownership bitmap and versions
// depends on gha_pkg and gha_bitpick
//
// usage: a request beat is taken on a rising edge with start high and busy low.
// each result is shown on o_rsp for exactly one cycle with o_valid high; the
// receiver cannot stall, so results simply go out as they are produced.
// the capacity register is written through i_cfg_we / i_cfg_wdata; the user
// must do so only while idle, and the block does not enforce this. destroy,
// exists and read slot do one version memory read, then give the result;
// out-of-range indices, unused codes and ignored scans are answered straight
// from idle. create walks the bitmap one word per cycle through the shared
// bit picker, up to 16 words, and answers no when no slot is free.
// a scan picks a bit, then reads its version, for each result in turn.
// clear all sweeps the 1024-entry version memory one entry per cycle, then
// gives its result.
// reset: the bitmap and live count clear at once, then the same clearing
// pass writes version 1 to every slot; busy stays high meanwhile and no
// result is produced for it.
// one request is handled at a time; busy is high until its last result.
`default_nettype none
module generational_handle_allocator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire gha_pkg::t_req_beat         i_req,
    output logic                            o_valid,
    output gha_pkg::t_rsp_beat              o_rsp,
    input  wire logic                       i_cfg_we,
    input  wire logic [gha_pkg::CNT_W-1:0]  i_cfg_wdata
);
    localparam int SW = gha_pkg::SLOT_W;
    localparam int VW = gha_pkg::VER_W;
    localparam int CW = gha_pkg::CNT_W;
    localparam int WB = gha_pkg::WORD_BITS;
    localparam int PW = gha_pkg::POS_W;
    localparam int WW = gha_pkg::WORD_W;

    gha_pkg::t_state    r_state, n_state;
    gha_pkg::t_req_beat r_req, n_req;
    logic [WW-1:0]      r_word, n_word;
    logic [WB-1:0]      r_scan, n_scan;
    logic [SW-1:0]      r_clr_addr, n_clr_addr;
    logic               r_clr_reply, n_clr_reply;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_cap;
    logic [WB-1:0]      r_bitmap [gha_pkg::NWORDS];
    logic [WB-1:0]      n_bitmap [gha_pkg::NWORDS];
    logic [SW-1:0]      r_slot, n_slot;
    logic [VW-1:0]      r_rdata;
    logic               r_out_valid, n_out_valid;
    gha_pkg::t_rsp_beat r_rsp, n_rsp;

    // version memory
    logic [VW-1:0] r_mem [gha_pkg::MAX_SLOTS];
    logic          mem_we;
    logic [SW-1:0] mem_waddr, mem_raddr;
    logic [VW-1:0] mem_wdata;

    // derived capacity values
    logic [CW-1:0] cap_eff;
    logic [CW:0]   words_sum;
    logic [CW-PW:0] words_cnt;
    logic [WB-1:0] cap_mask;
    logic          word_is_last;
    logic          idx_in_range;
    logic          wi_in_range;
    logic [VW:0]   ver_inc;
    logic [VW-1:0] ver_bump;

    // shared picker
    logic [WB-1:0] pick_vec;
    logic          pick_rev;
    logic          pick_found;
    logic [PW-1:0] pick_pos;

    gha_bitpick u_pick (
        .i_vec   (pick_vec),
        .i_rev   (pick_rev),
        .o_found (pick_found),
        .o_pos   (pick_pos)
    );

    assign cap_eff   = (r_cap > CW'(gha_pkg::MAX_SLOTS)) ? CW'(gha_pkg::MAX_SLOTS) : r_cap;
    assign words_sum = {1'b0, cap_eff} + (CW+1)'(WB - 1);
    assign words_cnt = words_sum[CW:PW];
    assign idx_in_range = {1'b0, i_req.entity_index} < cap_eff;
    assign wi_in_range  = (CW-PW+1)'(i_req.word_index) < words_cnt;
    assign word_is_last = ({1'b0, r_word, PW'(0)} + CW'(WB)) >= cap_eff;
    assign ver_inc  = {1'b0, r_rdata} + (VW+1)'(1);
    assign ver_bump = (ver_inc > (VW+1)'(gha_pkg::VERSION_LIMIT)) ? VW'(1) : ver_inc[VW-1:0];

    // slots of the current word that lie below the capacity
    always_comb begin
        for (int b = 0; b < WB; b++) begin
            cap_mask[b] = {1'b0, r_word, PW'(b)} < cap_eff;
        end
    end

    // picker input selection
    always_comb begin
        pick_vec = r_scan;
        pick_rev = (r_req.req_type == gha_pkg::REQ_SCAN_REV);
        if (r_state == gha_pkg::S_FIND) begin
            pick_vec = ~r_bitmap[r_word] & cap_mask;
            pick_rev = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gha_pkg::S_CLEAR: begin
                if (r_clr_addr == SW'(gha_pkg::MAX_SLOTS - 1)) n_state = gha_pkg::S_IDLE;
            end
            gha_pkg::S_IDLE: begin
                if (start) begin
                    priority case (i_req.req_type)
                        gha_pkg::REQ_CREATE: n_state = gha_pkg::S_FIND;
                        gha_pkg::REQ_DESTROY, gha_pkg::REQ_EXISTS, gha_pkg::REQ_READ: begin
                            if (idx_in_range) n_state = gha_pkg::S_USE;
                        end
                        gha_pkg::REQ_CLEAR: n_state = gha_pkg::S_CLEAR;
                        gha_pkg::REQ_SCAN_FWD, gha_pkg::REQ_SCAN_REV: begin
                            if (wi_in_range) n_state = gha_pkg::S_SCAN;
                        end
                        default: n_state = gha_pkg::S_IDLE;
                    endcase
                end
            end
            gha_pkg::S_FIND: begin
                if (pick_found)        n_state = gha_pkg::S_USE;
                else if (word_is_last) n_state = gha_pkg::S_IDLE;
            end
            gha_pkg::S_USE: n_state = gha_pkg::S_IDLE;
            gha_pkg::S_SCAN: begin
                n_state = pick_found ? gha_pkg::S_SCAN_USE : gha_pkg::S_IDLE;
            end
            gha_pkg::S_SCAN_USE: begin
                n_state = (r_scan == '0) ? gha_pkg::S_IDLE : gha_pkg::S_SCAN;
            end
            default: n_state = gha_pkg::S_IDLE;
        endcase
    end

    // datapath and result beat
    always_comb begin
        n_req       = r_req;
        n_word      = r_word;
        n_scan      = r_scan;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_count     = r_count;
        n_bitmap    = r_bitmap;
        n_slot      = r_slot;
        n_out_valid = 1'b0;
        n_rsp       = '0;
        mem_we      = 1'b0;
        mem_waddr   = r_slot;
        mem_wdata   = r_rdata;
        mem_raddr   = r_slot;
        unique case (r_state)
            gha_pkg::S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = VW'(1);
                n_clr_addr = r_clr_addr + SW'(1);
                if (r_clr_addr == SW'(gha_pkg::MAX_SLOTS - 1)) begin
                    n_clr_reply = 1'b0;
                    if (r_clr_reply) begin
                        n_out_valid  = 1'b1;
                        n_rsp.status = gha_pkg::ST_OK;
                        n_rsp.last   = 1'b1;
                    end
                end
            end
            gha_pkg::S_IDLE: begin
                if (start) begin
                    n_req     = i_req;
                    n_slot    = i_req.entity_index;
                    mem_raddr = i_req.entity_index;
                    n_word    = '0;
                    priority case (i_req.req_type)
                        gha_pkg::REQ_CREATE: n_word = '0;
                        gha_pkg::REQ_DESTROY, gha_pkg::REQ_EXISTS, gha_pkg::REQ_READ: begin
                            if (!idx_in_range) begin
                                n_out_valid     = 1'b1;
                                n_rsp.status    = (i_req.req_type == gha_pkg::REQ_EXISTS)
                                                  ? gha_pkg::ST_NO : gha_pkg::ST_IGN;
                                n_rsp.out_index = i_req.entity_index;
                                n_rsp.last      = 1'b1;
                            end
                        end
                        gha_pkg::REQ_CLEAR: begin
                            for (int w = 0; w < gha_pkg::NWORDS; w++) n_bitmap[w] = '0;
                            n_count     = '0;
                            n_clr_addr  = '0;
                            n_clr_reply = 1'b1;
                        end
                        gha_pkg::REQ_SCAN_FWD, gha_pkg::REQ_SCAN_REV: begin
                            if (wi_in_range) begin
                                n_scan = r_bitmap[i_req.word_index];
                                n_word = i_req.word_index;
                            end else begin
                                n_out_valid  = 1'b1;
                                n_rsp.status = gha_pkg::ST_IGN;
                                n_rsp.last   = 1'b1;
                            end
                        end
                        default: begin
                            n_out_valid  = 1'b1;
                            n_rsp.status = gha_pkg::ST_IGN;
                            n_rsp.last   = 1'b1;
                        end
                    endcase
                end
            end
            gha_pkg::S_FIND: begin
                if (pick_found) begin
                    n_bitmap[r_word][pick_pos] = 1'b1;
                    n_count   = r_count + CW'(1);
                    n_slot    = {r_word, pick_pos};
                    mem_raddr = {r_word, pick_pos};
                end else if (word_is_last) begin
                    n_out_valid  = 1'b1;
                    n_rsp.status = gha_pkg::ST_NO;
                    n_rsp.last   = 1'b1;
                end else begin
                    n_word = r_word + WW'(1);
                end
            end
            gha_pkg::S_USE: begin
                n_out_valid     = 1'b1;
                n_rsp.out_index = r_slot;
                n_rsp.last      = 1'b1;
                priority case (r_req.req_type)
                    gha_pkg::REQ_CREATE: begin
                        n_rsp.status      = gha_pkg::ST_OK;
                        n_rsp.out_version = r_rdata;
                    end
                    gha_pkg::REQ_DESTROY: begin
                        if (r_rdata != r_req.entity_version) begin
                            n_rsp.status      = gha_pkg::ST_NO;
                            n_rsp.out_version = r_rdata;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_slot;
                            mem_wdata = ver_bump;
                            n_bitmap[r_slot[SW-1:PW]][r_slot[PW-1:0]] = 1'b0;
                            if (r_count != '0) n_count = r_count - CW'(1);
                            n_rsp.status      = gha_pkg::ST_OK;
                            n_rsp.out_version = ver_bump;
                        end
                    end
                    gha_pkg::REQ_EXISTS: begin
                        n_rsp.status      = (r_rdata == r_req.entity_version)
                                            ? gha_pkg::ST_OK : gha_pkg::ST_NO;
                        n_rsp.out_version = r_rdata;
                    end
                    default: begin
                        if (r_bitmap[r_slot[SW-1:PW]][r_slot[PW-1:0]]) begin
                            n_rsp.status      = gha_pkg::ST_OK;
                            n_rsp.out_version = r_rdata;
                        end else begin
                            n_rsp.status = gha_pkg::ST_NO;
                        end
                    end
                endcase
            end
            gha_pkg::S_SCAN: begin
                if (pick_found) begin
                    n_scan[pick_pos] = 1'b0;
                    n_slot    = {r_word, pick_pos};
                    mem_raddr = {r_word, pick_pos};
                end else begin
                    n_out_valid  = 1'b1;
                    n_rsp.status = gha_pkg::ST_NO;
                    n_rsp.last   = 1'b1;
                end
            end
            gha_pkg::S_SCAN_USE: begin
                n_out_valid       = 1'b1;
                n_rsp.status      = gha_pkg::ST_OK;
                n_rsp.out_index   = r_slot;
                n_rsp.out_version = r_rdata;
                n_rsp.last        = (r_scan == '0);
            end
            default: n_out_valid = 1'b0;
        endcase
        n_rsp.live_count = n_count;
    end

    // version memory port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_word <= n_word;
        r_scan <= n_scan;
        r_slot <= n_slot;
        r_rsp  <= n_rsp;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gha_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cap       <= CW'(gha_pkg::MAX_SLOTS);
            for (int w = 0; w < gha_pkg::NWORDS; w++) r_bitmap[w] <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_bitmap    <= n_bitmap;
            if (i_cfg_we) r_cap <= i_cfg_wdata;
        end
    end

    assign busy    = (r_state != gha_pkg::S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;
endmodule
`default_nettype wire

[rtl/gha_bitpick.sv]
// gha_bitpick: shared bit picker, lowest or highest set bit of one bitmap word
// depends on gha_pkg
`default_nettype none
module gha_bitpick (
    input  wire logic [gha_pkg::WORD_BITS-1:0] i_vec,
    input  wire logic                          i_rev,
    output logic                               o_found,
    output logic [gha_pkg::POS_W-1:0]          o_pos
);
    // priority pick, direction chosen by i_rev
    always_comb begin
        o_pos   = '0;
        o_found = |i_vec;
        if (i_rev) begin
            for (int i = 0; i < gha_pkg::WORD_BITS; i++) begin
                if (i_vec[i]) o_pos = gha_pkg::POS_W'(i);
            end
        end else begin
            for (int i = gha_pkg::WORD_BITS - 1; i >= 0; i--) begin
                if (i_vec[i]) o_pos = gha_pkg::POS_W'(i);
            end
        end
    end
endmodule
`default_nettype wire

[rtl/gha_checker.sv]
// gha_checker: port-level assertions for generational_handle_allocator
// depends on gha_pkg; bound to the top level below
`default_nettype none
module gha_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_valid,
    input wire gha_pkg::t_rsp_beat o_rsp
);
    // an accepted request shows work or a result on the next cycle
    a_accept_reacts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted request produced neither busy nor a result");

    // a beat that is not last must be followed by more work
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.last) |=> busy)
        else $error("non-last result not followed by busy");

    // only successful scan results may be non-last
    a_nonlast_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.last) |-> (o_rsp.status == gha_pkg::ST_OK))
        else $error("non-last result with failing status");

    // ignored requests give a single final beat
    a_ign_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == gha_pkg::ST_IGN) |-> o_rsp.last)
        else $error("ignored request result not last");

    // live count never exceeds the slot count
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.live_count <= gha_pkg::CNT_W'(gha_pkg::MAX_SLOTS)))
        else $error("live count out of range");
endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);
`default_nettype wire

[dv/gha_checker.sv]
// gha_scoreboard: watches the request, result and capacity ports of the allocator,
// predicts every result beat and compares them field by field; uses gha_pkg
`timescale 1ns / 1ps
`default_nettype none
module gha_scoreboard (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire gha_pkg::t_req_beat         i_req,
    input  wire logic                       o_valid,
    input  wire gha_pkg::t_rsp_beat         o_rsp,
    input  wire logic                       i_cfg_we,
    input  wire logic [gha_pkg::CNT_W-1:0]  i_cfg_wdata,
    output int                              o_pending,
    output int                              o_fail_count,
    output int                              o_checked
);
    // mirror of the allocator store
    logic                      slot_owned [gha_pkg::MAX_SLOTS];
    logic [gha_pkg::VER_W-1:0] slot_ver   [gha_pkg::MAX_SLOTS];
    int unsigned               live_total;
    int unsigned               capacity;
    gha_pkg::t_rsp_beat        expected_beats[$];

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        o_pending    = 0;
    end

    function automatic void clear_mirror();
        for (int i = 0; i < gha_pkg::MAX_SLOTS; i++) begin
            slot_owned[i] = 1'b0;
            slot_ver[i]   = gha_pkg::VER_W'(1);
        end
        live_total = 0;
    endfunction

    function automatic void push_beat(logic [1:0] st, int unsigned idx,
                                      logic [gha_pkg::VER_W-1:0] ver, logic lst);
        gha_pkg::t_rsp_beat b;
        b.status      = st;
        b.out_index   = idx[gha_pkg::SLOT_W-1:0];
        b.out_version = ver;
        b.live_count  = live_total[gha_pkg::CNT_W-1:0];
        b.last        = lst;
        expected_beats.push_back(b);
    endfunction

    // work out the result beats of one accepted request and update the mirror
    function automatic void predict_request(gha_pkg::t_req_beat r);
        int unsigned      cap;
        int unsigned      idx;
        int unsigned      words;
        int unsigned      bpos;
        int unsigned      slot;
        int               n;
        bit               found;
        cap   = (capacity > gha_pkg::MAX_SLOTS) ? gha_pkg::MAX_SLOTS : capacity;
        idx   = r.entity_index;
        found = 0;
        n     = 0;
        case (r.req_type)
            gha_pkg::REQ_CREATE: begin
                for (int i = 0; i < cap && !found; i++) begin
                    if (!slot_owned[i]) begin
                        slot_owned[i] = 1'b1;
                        live_total++;
                        push_beat(gha_pkg::ST_OK, i, slot_ver[i], 1'b1);
                        found = 1;
                    end
                end
                if (!found) push_beat(gha_pkg::ST_NO, 0, '0, 1'b1);
            end
            gha_pkg::REQ_DESTROY: begin
                if (idx >= cap) begin
                    push_beat(gha_pkg::ST_IGN, idx, '0, 1'b1);
                end else if (slot_ver[idx] != r.entity_version) begin
                    push_beat(gha_pkg::ST_NO, idx, slot_ver[idx], 1'b1);
                end else begin
                    // a free slot with a matching version is bumped too
                    slot_owned[idx] = 1'b0;
                    slot_ver[idx]   = (slot_ver[idx] == gha_pkg::VERSION_LIMIT)
                                      ? gha_pkg::VER_W'(1)
                                      : slot_ver[idx] + gha_pkg::VER_W'(1);
                    if (live_total > 0) live_total--;
                    push_beat(gha_pkg::ST_OK, idx, slot_ver[idx], 1'b1);
                end
            end
            gha_pkg::REQ_EXISTS: begin
                if (idx >= cap)
                    push_beat(gha_pkg::ST_NO, idx, '0, 1'b1);
                else
                    push_beat((slot_ver[idx] == r.entity_version) ? gha_pkg::ST_OK
                                                                  : gha_pkg::ST_NO,
                              idx, slot_ver[idx], 1'b1);
            end
            gha_pkg::REQ_READ: begin
                if (idx >= cap)
                    push_beat(gha_pkg::ST_IGN, idx, '0, 1'b1);
                else if (!slot_owned[idx])
                    push_beat(gha_pkg::ST_NO, idx, '0, 1'b1);
                else
                    push_beat(gha_pkg::ST_OK, idx, slot_ver[idx], 1'b1);
            end
            gha_pkg::REQ_CLEAR: begin
                clear_mirror();
                push_beat(gha_pkg::ST_OK, 0, '0, 1'b1);
            end
            gha_pkg::REQ_SCAN_FWD, gha_pkg::REQ_SCAN_REV: begin
                words = (cap + gha_pkg::WORD_BITS - 1) / gha_pkg::WORD_BITS;
                if (r.word_index >= words) begin
                    push_beat(gha_pkg::ST_IGN, 0, '0, 1'b1);
                end else begin
                    // owned slots above a lowered capacity are listed as well
                    for (int p = 0; p < gha_pkg::WORD_BITS; p++) begin
                        bpos = (r.req_type == gha_pkg::REQ_SCAN_FWD)
                               ? p : gha_pkg::WORD_BITS - 1 - p;
                        slot = r.word_index * gha_pkg::WORD_BITS + bpos;
                        if (slot_owned[slot]) begin
                            push_beat(gha_pkg::ST_OK, slot, slot_ver[slot], 1'b0);
                            n++;
                        end
                    end
                    if (n == 0)
                        push_beat(gha_pkg::ST_NO, 0, '0, 1'b1);
                    else
                        expected_beats[expected_beats.size()-1].last = 1'b1;
                end
            end
            default: begin
                push_beat(gha_pkg::ST_IGN, 0, '0, 1'b1);
            end
        endcase
    endfunction

    // compare one result beat with the oldest expectation
    function automatic void check_beat(gha_pkg::t_rsp_beat got);
        gha_pkg::t_rsp_beat e;
        if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected: %p", got);
            o_fail_count++;
            return;
        end
        e = expected_beats.pop_front();
        o_checked++;
        if (got.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, got.status);
            o_fail_count++;
        end
        if (got.out_index !== e.out_index) begin
            $error("out_index expected %0d actual %0d", e.out_index, got.out_index);
            o_fail_count++;
        end
        if (got.out_version !== e.out_version) begin
            $error("out_version expected %0d actual %0d", e.out_version, got.out_version);
            o_fail_count++;
        end
        if (got.live_count !== e.live_count) begin
            $error("live_count expected %0d actual %0d", e.live_count, got.live_count);
            o_fail_count++;
        end
        if (got.last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, got.last);
            o_fail_count++;
        end
    endfunction

    // sample mid-cycle: every port is stable between rising edges
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            clear_mirror();
            capacity = 1024;
            expected_beats.delete();
        end else begin
            if (o_valid) check_beat(o_rsp);
            if (i_cfg_we) capacity = i_cfg_wdata;
            if (start && !busy) predict_request(i_req);
        end
        o_pending = expected_beats.size();
    end
endmodule
`default_nettype wire

[dv/generational_handle_allocator_test.sv]
// generational_handle_allocator_test: stimulus and verdict for the allocator
// depends on gha_pkg, generational_handle_allocator and gha_scoreboard
`timescale 1ns / 1ps
`default_nettype none
module generational_handle_allocator_test;
    localparam logic [2:0] REQ_UNUSED  = 3'd7;
    localparam int         CYCLE_LIMIT = 1000000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    gha_pkg::t_req_beat         i_req;
    logic                       o_valid;
    gha_pkg::t_rsp_beat         o_rsp;
    logic                       i_cfg_we;
    logic [gha_pkg::CNT_W-1:0]  i_cfg_wdata;
    int                         pending;
    int                         fail_count;
    int                         checked;

    int                         cycles;
    int                         items_sent;
    int                         burst_left;
    bit                         no_gaps;
    logic [2:0]                 last_kind;
    int unsigned                cur_cap;
    logic [gha_pkg::SLOT_W-1:0] handle_idx[$];
    logic [gha_pkg::VER_W-1:0]  handle_ver[$];

    generational_handle_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    gha_scoreboard u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_valid      (o_valid),
        .o_rsp        (o_rsp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("run limit reached with %0d beats outstanding", pending);
            $display("generational_handle_allocator_test: FAIL");
            $finish;
        end
    end

    // collect handles handed out by create
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && last_kind == gha_pkg::REQ_CREATE &&
            o_rsp.status == gha_pkg::ST_OK) begin
            handle_idx.push_back(o_rsp.out_index);
            handle_ver.push_back(o_rsp.out_version);
        end
    end

    // one request beat; start stays high until the edge that takes it
    task automatic send(logic [2:0] kind, logic [gha_pkg::SLOT_W-1:0] idx,
                        logic [gha_pkg::VER_W-1:0] ver, logic [3:0] word);
        int  gap;
        bit  taken;
        gap = 0;
        if (!no_gaps) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 10);
            end
            burst_left--;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start                <= 1'b1;
        i_req.req_type       <= kind;
        i_req.entity_index   <= idx;
        i_req.entity_version <= ver;
        i_req.word_index     <= word;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        last_kind = kind;
        items_sent++;
        if (kind == gha_pkg::REQ_CLEAR) begin
            handle_idx.delete();
            handle_ver.delete();
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [gha_pkg::CNT_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_cap = value;
        @(posedge i_clk);
    endtask

    // destroy a live handle, taken out of the pool
    task automatic destroy_live();
        int k;
        k = $urandom_range(0, handle_idx.size() - 1);
        send(gha_pkg::REQ_DESTROY, handle_idx[k], handle_ver[k], 4'($urandom));
        handle_idx.delete(k);
        handle_ver.delete(k);
    endtask

    // mostly well-formed traffic on live handles, with some noise
    task automatic random_item();
        int                         sel;
        int                         k;
        int unsigned                words;
        logic [gha_pkg::SLOT_W-1:0] idx;
        logic [gha_pkg::VER_W-1:0]  ver;
        sel   = $urandom_range(0, 99);
        idx   = gha_pkg::SLOT_W'($urandom);
        ver   = gha_pkg::VER_W'($urandom);
        words = (cur_cap > gha_pkg::MAX_SLOTS ? gha_pkg::MAX_SLOTS : cur_cap)
                / gha_pkg::WORD_BITS + 1;
        if (handle_idx.size() > 0) begin
            k = $urandom_range(0, handle_idx.size() - 1);
            if ($urandom_range(0, 3) != 0) begin
                idx = handle_idx[k];
                ver = handle_ver[k];
            end
        end
        if (sel < 35)
            send(gha_pkg::REQ_CREATE, idx, ver, 4'($urandom));
        else if (sel < 52 && handle_idx.size() > 0)
            destroy_live();
        else if (sel < 60)
            send(gha_pkg::REQ_DESTROY, idx,
                 ($urandom_range(0, 1) ? ver : gha_pkg::VER_W'($urandom)), 4'($urandom));
        else if (sel < 68)
            send(gha_pkg::REQ_EXISTS, idx, ver, 4'($urandom));
        else if (sel < 77)
            send(gha_pkg::REQ_READ, idx, ver, 4'($urandom));
        else if (sel < 79)
            send(gha_pkg::REQ_CLEAR, idx, ver, 4'($urandom));
        else if (sel < 93)
            send($urandom_range(0, 1) ? gha_pkg::REQ_SCAN_FWD : gha_pkg::REQ_SCAN_REV,
                 idx, ver,
                 ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, words - 1))
                                             : 4'($urandom));
        else
            send(REQ_UNUSED, idx, ver, 4'($urandom));
    endtask

    task automatic random_run(int n);
        for (int i = 0; i < n; i++) begin
            // some stretches without any idling
            if (i % 16 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            random_item();
        end
        no_gaps = 0;
    endtask

    initial begin
        logic [gha_pkg::CNT_W-1:0] caps[6];
        caps        = '{11'd64, 11'd1, 11'd0, 11'd130, 11'd2047, 11'd1024};
        cycles      = 0;
        items_sent  = 0;
        burst_left  = 0;
        no_gaps     = 0;
        last_kind   = REQ_UNUSED;
        cur_cap     = 1024;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every code and empty cases
        send(gha_pkg::REQ_SCAN_FWD, '0, '0, 4'd0);
        send(gha_pkg::REQ_CREATE, '0, '0, '0);
        send(gha_pkg::REQ_CREATE, '1, '1, '1);
        send(gha_pkg::REQ_CREATE, '0, '0, '0);
        send(gha_pkg::REQ_EXISTS, 10'd1, 14'd1, '0);
        send(gha_pkg::REQ_EXISTS, 10'd1, 14'd2, '0);
        send(gha_pkg::REQ_READ, 10'd1, '0, '0);
        send(gha_pkg::REQ_READ, 10'd1023, '1, '1);
        send(gha_pkg::REQ_SCAN_FWD, '0, '0, 4'd0);
        send(gha_pkg::REQ_SCAN_REV, '1, '1, 4'd0);
        send(gha_pkg::REQ_SCAN_REV, '0, '0, 4'd15);
        send(gha_pkg::REQ_DESTROY, 10'd1, 14'd5, '0);
        send(gha_pkg::REQ_DESTROY, 10'd1, 14'd1, '0);
        send(gha_pkg::REQ_DESTROY, 10'd1, 14'd2, '0);
        send(gha_pkg::REQ_DESTROY, 10'd1023, 14'd1, '0);
        send(gha_pkg::REQ_READ, 10'd1, '0, '0);
        send(REQ_UNUSED, '1, '1, '1);
        send(gha_pkg::REQ_CLEAR, '1, '1, '1);
        send(gha_pkg::REQ_DESTROY, 10'd0, 14'd1, '0);
        send(gha_pkg::REQ_READ, 10'd0, '0, '0);
        random_run(12);

        // capacity sweep, down to zero and above the slot count
        foreach (caps[c]) begin
            write_capacity(caps[c]);
            if (caps[c] == 11'd1) begin
                send(gha_pkg::REQ_CREATE, '0, '0, '0);
                send(gha_pkg::REQ_CREATE, '0, '0, '0);
                send(gha_pkg::REQ_DESTROY, 10'd1, '0, '0);
                send(gha_pkg::REQ_READ, 10'd1, '0, '0);
                send(gha_pkg::REQ_EXISTS, 10'd1, '0, '0);
                send(gha_pkg::REQ_SCAN_FWD, '0, '0, 4'd1);
            end
            random_run(30);
        end

        // final clear and a lookup on the fresh store
        send(gha_pkg::REQ_CLEAR, '0, '0, '0);
        send(gha_pkg::REQ_EXISTS, '0, 14'd1, '0);

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("sent %0d requests over %0d capacity settings, %0d result beats checked",
                 items_sent, 7, checked);
        $display("covered create to full, stale and free-slot destroys, clears, scans");
        if (fail_count == 0)
            $display("generational_handle_allocator_test: PASS");
        else
            $display("generational_handle_allocator_test: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
